### rtl/aabb_move_collision_resolve_top_defines.svh
// Assertion macros for the moving-box collision resolver.
// Included by the top-level RTL file, which checks its own logic; no dependencies.
`ifndef AABB_MOVE_COLLISION_RESOLVE_TOP_DEFINES_SVH
`define AABB_MOVE_COLLISION_RESOLVE_TOP_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during rst
`define AMCR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("amcr check failed");
// next-cycle implication, sampled on clk, off during rst
`define AMCR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("amcr check failed");
`else
`define AMCR_ASSERT_IMP(name, ante, cons)
`define AMCR_ASSERT_NXT(name, ante, cons)
`endif
`endif

### rtl/amcr_pkg.sv
// Shared types, codes and saturation helpers for the collision resolver.
// No dependencies.
`default_nettype none

package amcr_pkg;

  localparam int CoordW = 16;
  localparam int StepW  = 8;
  localparam int CodeW  = 2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [StepW-1:0]  step_t;
  typedef logic [CodeW-1:0]         code_t;
  // one bit wider than a coordinate: sums and differences
  typedef logic signed [CoordW:0]   wide_t;

  // collision codes merge by OR
  localparam code_t CODE_NONE = 2'd0;
  localparam code_t CODE_X    = 2'd1;
  localparam code_t CODE_Y    = 2'd2;
  localparam code_t CODE_BOTH = 2'd3;

  // item kinds
  localparam logic FUNC_START    = 1'b0;
  localparam logic FUNC_COLLIDER = 1'b1;

  typedef struct packed {
    logic   func;
    coord_t box_left;
    coord_t box_top;
    coord_t box_right;
    coord_t box_bottom;
    step_t  step_x;
    step_t  step_y;
    logic   is_self;
    logic   last;
  } item_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
    step_t  step_x;
    step_t  step_y;
    code_t  code;
  } state_t;

  typedef struct packed {
    coord_t new_left;
    coord_t new_top;
    coord_t new_right;
    coord_t new_bottom;
    code_t  collision;
  } res_t;

  function automatic wide_t ext_coord(coord_t c);
    return {c[CoordW-1], c};
  endfunction

  function automatic wide_t ext_step(step_t s);
    return {{(CoordW+1-StepW){s[StepW-1]}}, s};
  endfunction

  // saturate a 17-bit value into 16 bits
  function automatic coord_t sat_coord(wide_t v);
    coord_t r;
    if (v[CoordW] == v[CoordW-1]) begin
      r = v[CoordW-1:0];
    end else if (v[CoordW]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

  // saturate a 17-bit value into 8 bits
  function automatic step_t sat_step(wide_t v);
    step_t r;
    if ((&v[CoordW:StepW-1]) || !(|v[CoordW:StepW-1])) begin
      r = v[StepW-1:0];
    end else if (v[CoordW]) begin
      r = {1'b1, {(StepW-1){1'b0}}};
    end else begin
      r = {1'b0, {(StepW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/amcr_in_if.sv
// Input channel of the collision resolver: valid/ready plus one item.
// Depends on amcr_pkg.
`default_nettype none

interface amcr_in_if import amcr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   func;
  coord_t box_left;
  coord_t box_top;
  coord_t box_right;
  coord_t box_bottom;
  step_t  step_x;
  step_t  step_y;
  logic   is_self;
  logic   last;

  modport source (
    output valid, func, box_left, box_top, box_right, box_bottom,
           step_x, step_y, is_self, last,
    input  ready
  );
  modport sink (
    input  valid, func, box_left, box_top, box_right, box_bottom,
           step_x, step_y, is_self, last,
    output ready
  );
endinterface

`default_nettype wire

### rtl/amcr_out_if.sv
// Result channel of the collision resolver: valid/ready plus moved box and code.
// Depends on amcr_pkg.
`default_nettype none

interface amcr_out_if import amcr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t new_left;
  coord_t new_top;
  coord_t new_right;
  coord_t new_bottom;
  code_t  collision;

  modport source (
    output valid, new_left, new_top, new_right, new_bottom, collision,
    input  ready
  );
  modport sink (
    input  valid, new_left, new_top, new_right, new_bottom, collision,
    output ready
  );
endinterface

`default_nettype wire

### rtl/amcr_resolve.sv
// Next-state logic of the resolver: load, one collider test, step application.
// Depends on amcr_pkg.
`default_nettype none

module amcr_resolve import amcr_pkg::*; (
  input  state_t st,
  input  item_t  item,
  output state_t st_next,
  output res_t   res
);

  step_t dx, dy;
  logic  dx_pos, dx_neg, dy_pos, dy_neg;
  wide_t ol, ot, orr, ob;
  wide_t sl, st_top, sr, sb;
  logic  overlap, hit;
  logic signed [CoordW+1:0] px, py;
  logic [CoordW+1:0] ax, ay;
  step_t nsx, nsy;
  code_t code_hit;
  state_t upd;
  coord_t nl, nt, nr, nb;

  assign dx = st.step_x;
  assign dy = st.step_y;
  assign dx_neg = dx[StepW-1];
  assign dy_neg = dy[StepW-1];
  assign dx_pos = !dx[StepW-1] && (|dx);
  assign dy_pos = !dy[StepW-1] && (|dy);

  assign ol  = ext_coord(item.box_left);
  assign ot  = ext_coord(item.box_top);
  assign orr = ext_coord(item.box_right);
  assign ob  = ext_coord(item.box_bottom);

  // mover edges shifted by the current step
  assign sl     = ext_coord(st.left)   + ext_step(dx);
  assign sr     = ext_coord(st.right)  + ext_step(dx);
  assign st_top = ext_coord(st.top)    + ext_step(dy);
  assign sb     = ext_coord(st.bottom) + ext_step(dy);

  // touching edges do not count
  assign overlap = (sr > ol) && (sl < orr) && (sb > ot) && (st_top < ob);
  assign hit = (item.func == FUNC_COLLIDER) && !item.is_self && overlap;

  // penetration depth per axis
  always_comb begin
    px = {{2{dx[StepW-1]}}, {(CoordW-StepW){dx[StepW-1]}}, dx};
    py = {{2{dy[StepW-1]}}, {(CoordW-StepW){dy[StepW-1]}}, dy};
    if (dx_pos) begin
      px = {sr[CoordW], sr} - {ol[CoordW], ol};
    end else if (dx_neg) begin
      px = {sl[CoordW], sl} - {orr[CoordW], orr};
    end
    if (dy_pos) begin
      py = {sb[CoordW], sb} - {ot[CoordW], ot};
    end else if (dy_neg) begin
      py = {st_top[CoordW], st_top} - {ob[CoordW], ob};
    end
    ax = px[CoordW+1] ? -px : px;
    ay = py[CoordW+1] ? -py : py;
  end

  // shortened step: the gap between facing edges
  assign nsx = dx_pos ? sat_step(ol - ext_coord(st.right))
                      : sat_step(orr - ext_coord(st.left));
  assign nsy = dy_pos ? sat_step(ot - ext_coord(st.bottom))
                      : sat_step(ob - ext_coord(st.top));

  // state after this item, before any step application
  always_comb begin
    upd      = st;
    code_hit = CODE_NONE;
    if (item.func == FUNC_START) begin
      upd.left   = item.box_left;
      upd.top    = item.box_top;
      upd.right  = item.box_right;
      upd.bottom = item.box_bottom;
      upd.step_x = item.step_x;
      upd.step_y = item.step_y;
      upd.code   = CODE_NONE;
    end else begin
      if (hit) begin
        if ((|dx) && (|dy)) begin
          if (ay < ax) begin
            upd.step_y = nsy;
            code_hit   = CODE_Y;
          end else if (ax < ay) begin
            upd.step_x = nsx;
            code_hit   = CODE_X;
          end else begin
            upd.step_x = nsx;
            upd.step_y = nsy;
            code_hit   = CODE_BOTH;
          end
        end else if (|dx) begin
          upd.step_x = nsx;
          code_hit   = CODE_X;
        end else if (|dy) begin
          upd.step_y = nsy;
          code_hit   = CODE_Y;
        end
      end
      upd.code = st.code | code_hit;
    end
  end

  // apply the step with saturation
  assign nl = sat_coord(ext_coord(upd.left)   + ext_step(upd.step_x));
  assign nr = sat_coord(ext_coord(upd.right)  + ext_step(upd.step_x));
  assign nt = sat_coord(ext_coord(upd.top)    + ext_step(upd.step_y));
  assign nb = sat_coord(ext_coord(upd.bottom) + ext_step(upd.step_y));

  assign res = '{new_left: nl, new_top: nt, new_right: nr, new_bottom: nb,
                 collision: upd.code};

  // a last item leaves the moved box with a cleared step and code
  always_comb begin
    st_next = upd;
    if (item.last) begin
      st_next.left   = nl;
      st_next.top    = nt;
      st_next.right  = nr;
      st_next.bottom = nb;
      st_next.step_x = '0;
      st_next.step_y = '0;
      st_next.code   = CODE_NONE;
    end
  end

endmodule

`default_nettype wire

### rtl/aabb_move_collision_resolve_top.sv
// Top level of the moving-box collision resolver: input register, state, result register.
// Depends on amcr_pkg, amcr_in_if, amcr_out_if, amcr_resolve and the defines header.
//
//   channel  | modport | beat
//   ---------+---------+-------------------------------------------------
//   item     | sink    | start (mover box + step) or collider box
//   result   | source  | moved box and merged collision code, on last only
//
// One item per cycle while no last item stalls; a result is valid once its last item
// has passed through the input register into the result register. Each item is resolved
// combinationally from the input register against the mover state; the mover/step/code
// registers close the loop between items. rst (synchronous) empties both registers and
// clears the mover state to zero. Only a last item waits for a full result register.
`default_nettype none
`include "aabb_move_collision_resolve_top_defines.svh"

module aabb_move_collision_resolve_top import amcr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  amcr_in_if.sink    item,
  amcr_out_if.source result
);

  item_t  q;
  logic   q_valid;
  logic   adv;
  state_t st, st_next;
  res_t   res_calc, res;
  logic   res_valid;

  // an item in the input register moves on unless it needs a busy result slot
  assign adv = q_valid && (!q.last || !res_valid || result.ready);
  assign item.ready = !q_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (item.ready) begin
      q_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      q <= '{func: item.func, box_left: item.box_left, box_top: item.box_top,
             box_right: item.box_right, box_bottom: item.box_bottom,
             step_x: item.step_x, step_y: item.step_y,
             is_self: item.is_self, last: item.last};
    end
  end

  amcr_resolve u_resolve (
    .st      (st),
    .item    (q),
    .st_next (st_next),
    .res     (res_calc)
  );

  // mover state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && q.last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (adv && q.last) begin
      res <= res_calc;
    end
  end

  assign result.valid      = res_valid;
  assign result.new_left   = res.new_left;
  assign result.new_top    = res.new_top;
  assign result.new_right  = res.new_right;
  assign result.new_bottom = res.new_bottom;
  assign result.collision  = res.collision;

  // checks
  `AMCR_ASSERT_NXT(a_last_gives_result, adv && q.last, res_valid)
  `AMCR_ASSERT_NXT(a_result_clears_step, adv && q.last,
    st.step_x == '0 && st.step_y == '0 && st.code == CODE_NONE)
  `AMCR_ASSERT_NXT(a_start_last_none, adv && q.last && q.func == FUNC_START,
    res.collision == CODE_NONE)
  `AMCR_ASSERT_NXT(a_both_sticky,
    adv && !q.last && q.func == FUNC_COLLIDER && st.code == CODE_BOTH,
    st.code == CODE_BOTH)
  `AMCR_ASSERT_NXT(a_zero_step_holds,
    adv && !q.last && q.func == FUNC_COLLIDER && st.step_x == '0 && st.step_y == '0,
    st.step_x == '0 && st.step_y == '0)

endmodule

`default_nettype wire

### tb/tb_amcr_move_checker.sv
`timescale 1ns / 100ps
// Checker for the moving-box collision resolver: watches both channels, predicts each move.
// Depends on amcr_pkg, amcr_in_if and amcr_out_if.
module tb_amcr_move_checker import amcr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  amcr_in_if        in_ch,
  amcr_out_if       out_ch,
  output int        fail_count,
  output int        owed
);

  // predicted mover state
  coord_t mv_left, mv_top, mv_right, mv_bottom;
  step_t  mv_step_x, mv_step_y;
  code_t  mv_code;

  res_t expected_moves[$];
  int   errors;

  assign fail_count = errors;

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  // test one obstacle against the stepped mover, shorten the step, return the axis code
  function automatic code_t resolve_collider(int ol, int ot, int orr, int ob);
    int ml, mt, mr, mb, dx, dy, px, py, ax, ay;
    ml = mv_left;
    mt = mv_top;
    mr = mv_right;
    mb = mv_bottom;
    dx = mv_step_x;
    dy = mv_step_y;
    px = dx;
    py = dy;
    // touching edges do not overlap
    if (mr + dx <= ol || ml + dx >= orr || mb + dy <= ot || mt + dy >= ob) return CODE_NONE;
    if (dx > 0) px = mr + dx - ol;
    else if (dx < 0) px = ml + dx - orr;
    if (dy > 0) py = mb + dy - ot;
    else if (dy < 0) py = mt + dy - ob;
    if (dx != 0 && dy != 0) begin
      ax = magnitude(px);
      ay = magnitude(py);
      if (ay < ax) begin
        mv_step_y = step_t'(clip(dy - py, -128, 127));
        return CODE_Y;
      end
      if (ax < ay) begin
        mv_step_x = step_t'(clip(dx - px, -128, 127));
        return CODE_X;
      end
      // equal penetration: back off on both axes
      mv_step_x = step_t'(clip(dx - px, -128, 127));
      mv_step_y = step_t'(clip(dy - py, -128, 127));
      return CODE_BOTH;
    end
    if (dx != 0) begin
      mv_step_x = step_t'(clip(dx - px, -128, 127));
      return CODE_X;
    end
    if (dy != 0) begin
      mv_step_y = step_t'(clip(dy - py, -128, 127));
      return CODE_Y;
    end
    return CODE_NONE;
  endfunction

  function automatic coord_t moved(coord_t c, step_t s);
    int sum;
    sum = int'(c) + int'(s);
    return coord_t'(clip(sum, -32768, 32767));
  endfunction

  // advance the predicted state by one accepted item; queue a result on last
  task automatic predict_move(input item_t it);
    res_t r;
    if (it.func == FUNC_START) begin
      mv_left   = it.box_left;
      mv_top    = it.box_top;
      mv_right  = it.box_right;
      mv_bottom = it.box_bottom;
      mv_step_x = it.step_x;
      mv_step_y = it.step_y;
      mv_code   = CODE_NONE;
    end else if (!it.is_self) begin
      mv_code = mv_code | resolve_collider(it.box_left, it.box_top, it.box_right, it.box_bottom);
    end
    if (it.last) begin
      mv_left   = moved(mv_left, mv_step_x);
      mv_top    = moved(mv_top, mv_step_y);
      mv_right  = moved(mv_right, mv_step_x);
      mv_bottom = moved(mv_bottom, mv_step_y);
      r.new_left   = mv_left;
      r.new_top    = mv_top;
      r.new_right  = mv_right;
      r.new_bottom = mv_bottom;
      r.collision  = mv_code;
      expected_moves.push_back(r);
      mv_step_x = '0;
      mv_step_y = '0;
      mv_code   = CODE_NONE;
    end
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t: MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
    errors++;
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) report_mismatch(what, want, got);
  endtask

  initial begin
    errors = 0;
    owed   = 0;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    item_t it;
    res_t  want;
    if (rst) begin
      mv_left   = '0;
      mv_top    = '0;
      mv_right  = '0;
      mv_bottom = '0;
      mv_step_x = '0;
      mv_step_y = '0;
      mv_code   = CODE_NONE;
      expected_moves.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        it.func       = in_ch.func;
        it.box_left   = in_ch.box_left;
        it.box_top    = in_ch.box_top;
        it.box_right  = in_ch.box_right;
        it.box_bottom = in_ch.box_bottom;
        it.step_x     = in_ch.step_x;
        it.step_y     = in_ch.step_y;
        it.is_self    = in_ch.is_self;
        it.last       = in_ch.last;
        predict_move(it);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_moves.size() == 0) begin
          report_mismatch("result beat with no move pending", 0, 1);
        end else begin
          want = expected_moves.pop_front();
          check_field("new_left", want.new_left, out_ch.new_left);
          check_field("new_top", want.new_top, out_ch.new_top);
          check_field("new_right", want.new_right, out_ch.new_right);
          check_field("new_bottom", want.new_bottom, out_ch.new_bottom);
          check_field("collision", want.collision, out_ch.collision);
        end
      end
    end
    owed = expected_moves.size();
  end

endmodule

### tb/tb_aabb_move_collision_resolve_top.sv
`timescale 1ns / 100ps
// Testbench top for the moving-box collision resolver: clock, reset, stimulus and verdict.
// Depends on amcr_pkg, both channel interfaces, the block and tb_amcr_move_checker.
module tb_aabb_move_collision_resolve_top;
  import amcr_pkg::*;

  localparam int RandomItems = 850;
  localparam int CycleLimit  = 500000;

  logic clk;
  logic rst;
  int   fail_count;
  int   owed;
  int   cycles;
  int   items_sent;
  bit   calm;

  amcr_in_if  item_ch ();
  amcr_out_if result_ch ();

  aabb_move_collision_resolve_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  tb_amcr_move_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (item_ch),
    .out_ch     (result_ch),
    .fail_count (fail_count),
    .owed       (owed)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // idle cycles before a beat; none at all during calm stretches
  function automatic int draw_gap();
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic item_t make_item(logic f, int l, int t, int r, int b,
                                      int sx, int sy, bit self_flag, bit last_flag);
    item_t it;
    it.func       = f;
    it.box_left   = coord_t'(l);
    it.box_top    = coord_t'(t);
    it.box_right  = coord_t'(r);
    it.box_bottom = coord_t'(b);
    it.step_x     = step_t'(sx);
    it.step_y     = step_t'(sy);
    it.is_self    = self_flag;
    it.last       = last_flag;
    return it;
  endfunction

  // drive one beat at the falling edge and hold it until taken
  task automatic send_item(input item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.func       = it.func;
    item_ch.box_left   = it.box_left;
    item_ch.box_top    = it.box_top;
    item_ch.box_right  = it.box_right;
    item_ch.box_bottom = it.box_bottom;
    item_ch.step_x     = it.step_x;
    item_ch.step_y     = it.step_y;
    item_ch.is_self    = it.is_self;
    item_ch.last       = it.last;
    item_ch.valid      = 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    items_sent++;
    if (items_sent % 60 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  // one move: start, up to six colliders near the stepped mover, last on the final beat unless the move is broken
  task automatic random_move();
    int  ml, mt, w, h, dx, dy, n, cw, chh, cl, ct;
    bit  broken;
    if ($urandom_range(0, 9) == 0) begin
      ml = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 200) : -32768 + $urandom_range(0, 200);
      mt = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 200) : -32768 + $urandom_range(0, 200);
    end else begin
      ml = $urandom_range(0, 600) - 300;
      mt = $urandom_range(0, 600) - 300;
    end
    w = $urandom_range(1, 60);
    h = $urandom_range(1, 60);
    case ($urandom_range(0, 3))
      0: begin dx = $urandom_range(0, 255) - 128; dy = $urandom_range(0, 255) - 128; end
      1: begin dx = $urandom_range(0, 20) - 10;   dy = $urandom_range(0, 20) - 10; end
      2: begin dx = 0;                            dy = $urandom_range(0, 255) - 128; end
      default: begin dx = $urandom_range(0, 255) - 128; dy = 0; end
    endcase
    n = $urandom_range(0, 6);
    broken = ($urandom_range(0, 19) == 0);
    send_item(make_item(FUNC_START, ml, mt, ml + w, mt + h, dx, dy,
                        1'($urandom_range(0, 1)), (n == 0) && !broken));
    for (int k = 0; k < n; k++) begin
      cw  = $urandom_range(1, 60);
      chh = $urandom_range(1, 60);
      cl  = ml + dx + $urandom_range(0, w + cw) - cw + $urandom_range(0, 20) - 10;
      ct  = mt + dy + $urandom_range(0, h + chh) - chh + $urandom_range(0, 20) - 10;
      send_item(make_item(FUNC_COLLIDER, cl, ct, cl + cw, ct + chh,
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          ($urandom_range(0, 7) == 0), (k == n - 1) && !broken));
    end
  endtask

  // result side: random hold-off before each result beat
  initial begin
    int gap;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        result_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    rst                = 1'b1;
    calm               = 1'b0;
    items_sent         = 0;
    item_ch.valid      = 1'b0;
    item_ch.func       = FUNC_START;
    item_ch.box_left   = '0;
    item_ch.box_top    = '0;
    item_ch.box_right  = '0;
    item_ch.box_bottom = '0;
    item_ch.step_x     = '0;
    item_ch.step_y     = '0;
    item_ch.is_self    = 1'b0;
    item_ch.last       = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // colliders before any start: zero step, reset mover
    send_item(make_item(FUNC_COLLIDER, -5, -5, 5, 5, 127, -128, 1'b0, 1'b0));
    send_item(make_item(FUNC_COLLIDER, -5, -5, 5, 5, 0, 0, 1'b1, 1'b1));
    // start with last, coordinates pushed past both ends
    send_item(make_item(FUNC_START, 32767, -32768, 32767, -32768, 127, -128, 1'b1, 1'b1));
    send_item(make_item(FUNC_START, -32768, 32767, -32768, 32767, -128, 127, 1'b0, 1'b1));
    // x hit then y hit merge to both; a self collider is skipped
    send_item(make_item(FUNC_START, 0, 0, 10, 10, 5, 3, 1'b0, 1'b0));
    send_item(make_item(FUNC_COLLIDER, 12, 0, 30, 10, -128, 127, 1'b0, 1'b0));
    send_item(make_item(FUNC_COLLIDER, 0, 12, 10, 20, 0, 0, 1'b0, 1'b0));
    send_item(make_item(FUNC_COLLIDER, 0, 0, 10, 10, 0, 0, 1'b1, 1'b1));
    // equal penetration on both axes
    send_item(make_item(FUNC_START, 0, 0, 10, 10, 4, 4, 1'b0, 1'b0));
    send_item(make_item(FUNC_COLLIDER, 12, 12, 20, 20, 0, 0, 1'b0, 1'b1));
    // touching edge is no hit
    send_item(make_item(FUNC_START, 0, 0, 10, 10, 2, 0, 1'b0, 1'b0));
    send_item(make_item(FUNC_COLLIDER, 12, 0, 20, 10, 0, 0, 1'b0, 1'b1));
    // overlap with zero step
    send_item(make_item(FUNC_START, 0, 0, 10, 10, 0, 0, 1'b0, 1'b0));
    send_item(make_item(FUNC_COLLIDER, 5, 5, 15, 15, 0, 0, 1'b0, 1'b1));
    // single axis, moving up
    send_item(make_item(FUNC_START, 0, 0, 10, 10, 0, -6, 1'b0, 1'b0));
    send_item(make_item(FUNC_COLLIDER, 0, -20, 10, -3, 0, 0, 1'b0, 1'b1));
    // already overlapping: shortened step saturates high, then low
    send_item(make_item(FUNC_START, 0, 0, 100, 10, -5, 0, 1'b0, 1'b0));
    send_item(make_item(FUNC_COLLIDER, -300, 0, 300, 10, 0, 0, 1'b0, 1'b1));
    send_item(make_item(FUNC_START, 0, 0, 400, 10, 5, 0, 1'b0, 1'b0));
    send_item(make_item(FUNC_COLLIDER, 0, 0, 10, 10, 0, 0, 1'b0, 1'b1));
    // negative diagonal, abandoned move, then extreme collider fields
    send_item(make_item(FUNC_START, 20, 20, 30, 30, -8, -8, 1'b0, 1'b0));
    send_item(make_item(FUNC_COLLIDER, 0, 0, 15, 25, 0, 0, 1'b0, 1'b0));
    send_item(make_item(FUNC_START, -32768, -32768, 32767, 32767, 127, 127, 1'b1, 1'b0));
    send_item(make_item(FUNC_COLLIDER, -32768, -32768, 32767, 32767, -1, -1, 1'b0, 1'b1));

    // random part: mostly well-formed moves, some raw noise beats
    while (items_sent < RandomItems + 24) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(item_t'({$urandom, $urandom, $urandom}));
      end else begin
        random_move();
      end
    end
    item_ch.valid = 1'b0;

    while (owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
